// File: design/snc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snc_pkg
// Types and constants shared by the IPv4 subnet calculator pipeline.
// ----------------------------------------------------------------------------
package snc_pkg;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NONCONTIG = 2'd1,
    STAT_RANGE     = 2'd2
  } status_t;

  localparam logic [2:0] CLS_LOOPBACK = 3'd0;
  localparam logic [2:0] CLS_A        = 3'd1;
  localparam logic [2:0] CLS_B        = 3'd2;
  localparam logic [2:0] CLS_C        = 3'd3;
  localparam logic [2:0] CLS_D        = 3'd4;
  localparam logic [2:0] CLS_E        = 3'd5;

  localparam logic [7:0] OCT_LOOPBACK = 8'd127;
  localparam logic [7:0] OCT_B_LO     = 8'd128;
  localparam logic [7:0] OCT_C_LO     = 8'd192;
  localparam logic [7:0] OCT_D_LO     = 8'd224;
  localparam logic [7:0] OCT_E_LO     = 8'd240;
  localparam logic [7:0] OCT_PRIV_A   = 8'd10;
  localparam logic [7:0] OCT_PRIV_B   = 8'd172;
  localparam logic [3:0] NIB_PRIV_B   = 4'h1;
  localparam logic [15:0] PFX_PRIV_C  = 16'hC0A8;
  localparam logic [15:0] PFX_LINK    = 16'hA9FE;

  localparam logic [5:0] PREFIX_MAX   = 6'd32;
  localparam logic [5:0] PREFIX_P2P   = 6'd31;

  typedef struct packed {
    logic        mode;
    logic [31:0] ip_addr;
    logic [31:0] mask_word;
    logic [5:0]  prefix_len;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  prefix_out;
    logic [31:0] network_addr;
    logic [31:0] broadcast_addr;
    logic [31:0] netmask;
    logic [31:0] wildcard_res;
    logic [31:0] first_host;
    logic [31:0] last_host;
    logic [31:0] host_count;
    logic [32:0] total_addresses;
    logic [2:0]  addr_class;
    logic        is_private;
  } out_item_t;

  // After the mask check: per-byte one counts of the mask word.
  typedef struct packed {
    logic        mode;
    logic [31:0] ip_addr;
    logic [5:0]  prefix_len;
    logic        contig;
    logic [3:0]  cnt3;
    logic [3:0]  cnt2;
    logic [3:0]  cnt1;
    logic [3:0]  cnt0;
  } chk_t;

  // After prefix resolution.
  typedef struct packed {
    status_t     status;
    logic [5:0]  prefix;
    logic [31:0] ip_addr;
  } pfx_t;

  // After mask expansion.
  typedef struct packed {
    status_t     status;
    logic [5:0]  prefix;
    logic [31:0] ip_addr;
    logic [31:0] mask;
    logic [31:0] net;
    logic [31:0] bcast;
    logic [32:0] total;
  } span_t;

endpackage

// File: design/snc_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snc_check
// Stage one: mask contiguity test and per-byte one counts of the mask.
// ----------------------------------------------------------------------------
module snc_check (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  snc_pkg::in_item_t in_data,
  output logic              out_valid,
  output snc_pkg::chk_t     out_data
);

  function automatic logic [3:0] byte_ones(input logic [7:0] b);
    logic [3:0] c;
    c = 4'd0;
    for (int k = 0; k < 8; k++) begin
      c = c + {3'd0, b[k]};
    end
    return c;
  endfunction

  logic [31:0]   inv;
  logic [31:0]   inv_inc;
  snc_pkg::chk_t data_nxt;
  logic          valid_r;
  snc_pkg::chk_t data_r;

  always_comb begin
    inv     = ~in_data.mask_word;
    inv_inc = inv + 32'd1;
    data_nxt.mode       = in_data.mode;
    data_nxt.ip_addr    = in_data.ip_addr;
    data_nxt.prefix_len = in_data.prefix_len;
    // A contiguous mask has an inverse of the form 0...01...1.
    data_nxt.contig     = ((inv & inv_inc) == 32'd0);
    data_nxt.cnt3       = byte_ones(in_data.mask_word[31:24]);
    data_nxt.cnt2       = byte_ones(in_data.mask_word[23:16]);
    data_nxt.cnt1       = byte_ones(in_data.mask_word[15:8]);
    data_nxt.cnt0       = byte_ones(in_data.mask_word[7:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: design/snc_prefix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snc_prefix
// Stage two: resolves the prefix length and the status code.
// ----------------------------------------------------------------------------
module snc_prefix (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  snc_pkg::chk_t in_data,
  output logic          out_valid,
  output snc_pkg::pfx_t out_data
);

  logic [5:0]    mask_ones;
  snc_pkg::pfx_t data_nxt;
  logic          valid_r;
  snc_pkg::pfx_t data_r;

  always_comb begin
    mask_ones = ({2'd0, in_data.cnt3} + {2'd0, in_data.cnt2})
              + ({2'd0, in_data.cnt1} + {2'd0, in_data.cnt0});
    data_nxt.ip_addr = in_data.ip_addr;
    data_nxt.status  = snc_pkg::STAT_OK;
    data_nxt.prefix  = mask_ones;
    if (in_data.mode) begin
      data_nxt.prefix = in_data.prefix_len;
      if (in_data.prefix_len > snc_pkg::PREFIX_MAX) begin
        data_nxt.status = snc_pkg::STAT_RANGE;
      end
    end else if (!in_data.contig) begin
      data_nxt.status = snc_pkg::STAT_NONCONTIG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: design/snc_span.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snc_span
// Stage three: builds the mask, network, broadcast and total address count.
// ----------------------------------------------------------------------------
module snc_span (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  snc_pkg::pfx_t  in_data,
  output logic           out_valid,
  output snc_pkg::span_t out_data
);

  logic [5:0]     host_bits;
  snc_pkg::span_t data_nxt;
  logic           valid_r;
  snc_pkg::span_t data_r;

  always_comb begin
    host_bits         = snc_pkg::PREFIX_MAX - in_data.prefix;
    data_nxt.status   = in_data.status;
    data_nxt.prefix   = in_data.prefix;
    data_nxt.ip_addr  = in_data.ip_addr;
    // A shift of 32 leaves zero, so prefix 32 gives an all-ones mask, while
    // prefix 0 shifts nothing and gives an all-zero mask.
    data_nxt.mask     = ~(32'hFFFF_FFFF >> in_data.prefix);
    data_nxt.net      = in_data.ip_addr & data_nxt.mask;
    data_nxt.bcast    = data_nxt.net | ~data_nxt.mask;
    data_nxt.total    = 33'd1 << host_bits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: design/snc_host.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snc_host
// Stage four: host range, host count, address class and private flag.
// ----------------------------------------------------------------------------
module snc_host (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  snc_pkg::span_t     in_data,
  output logic               out_valid,
  output snc_pkg::out_item_t out_data
);

  logic [7:0]         oct1;
  logic [2:0]         cls;
  logic               priv;
  logic [32:0]        total_m2;
  snc_pkg::out_item_t data_nxt;
  logic               valid_r;
  snc_pkg::out_item_t data_r;

  always_comb begin
    oct1 = in_data.ip_addr[31:24];
    priority if (oct1 == snc_pkg::OCT_LOOPBACK) begin
      cls = snc_pkg::CLS_LOOPBACK;
    end else if (oct1 < snc_pkg::OCT_B_LO) begin
      cls = snc_pkg::CLS_A;
    end else if (oct1 < snc_pkg::OCT_C_LO) begin
      cls = snc_pkg::CLS_B;
    end else if (oct1 < snc_pkg::OCT_D_LO) begin
      cls = snc_pkg::CLS_C;
    end else if (oct1 < snc_pkg::OCT_E_LO) begin
      cls = snc_pkg::CLS_D;
    end else begin
      cls = snc_pkg::CLS_E;
    end

    priv = (oct1 == snc_pkg::OCT_PRIV_A)
        || (oct1 == snc_pkg::OCT_PRIV_B && in_data.ip_addr[23:20] == snc_pkg::NIB_PRIV_B)
        || (in_data.ip_addr[31:16] == snc_pkg::PFX_PRIV_C)
        || (in_data.ip_addr[31:16] == snc_pkg::PFX_LINK);

    total_m2 = in_data.total - 33'd2;

    data_nxt.status          = in_data.status;
    data_nxt.prefix_out      = in_data.prefix;
    data_nxt.network_addr    = in_data.net;
    data_nxt.broadcast_addr  = in_data.bcast;
    data_nxt.netmask         = in_data.mask;
    data_nxt.wildcard_res    = ~in_data.mask;
    data_nxt.total_addresses = in_data.total;
    data_nxt.addr_class      = cls;
    data_nxt.is_private      = priv;
    if (in_data.prefix >= snc_pkg::PREFIX_P2P) begin
      data_nxt.first_host = 32'd0;
      data_nxt.last_host  = 32'd0;
      data_nxt.host_count = (in_data.prefix == snc_pkg::PREFIX_MAX) ? 32'd1 : 32'd2;
    end else begin
      data_nxt.first_host = in_data.net + 32'd1;
      data_nxt.last_host  = in_data.bcast - 32'd1;
      data_nxt.host_count = total_m2[31:0];
    end

    // An error result carries only its status code.
    if (in_data.status != snc_pkg::STAT_OK) begin
      data_nxt        = '0;
      data_nxt.status = in_data.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: design/ipv4_subnet_calculator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_subnet_calculator
// Four-stage pipeline that derives subnet facts from an IPv4 address and
// either a dotted netmask or a prefix length.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   in_*      input      in_valid / in_stall  snc_pkg::in_item_t
//   out_*     output     out_valid / out_stall snc_pkg::out_item_t
//
// Every item passes through four register stages: mask check, prefix
// resolution, mask expansion, host range; the last stage register drives
// the output. One item can be accepted in every cycle that in_stall is low.
// A stage takes a new item whenever it is empty or the stage after it moves
// on, so bubbles are squeezed out while the output is stalled; in_stall rises
// only when all four stages hold items and out_stall is high.
// The synchronous, active-low reset empties the pipeline; the data registers
// are not reset.
//
module ipv4_subnet_calculator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  snc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output snc_pkg::out_item_t out_item
);

  logic           v1, v2, v3, v4;
  logic           en1, en2, en3, en4;
  snc_pkg::chk_t  d1;
  snc_pkg::pfx_t  d2;
  snc_pkg::span_t d3;

  // Ready chain runs back from the output. A stage loads when it is empty or
  // its current item moves on in the same cycle, so nothing is dropped.
  assign en4      = !v4 || !out_stall;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  snc_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en1),
    .in_valid  (in_valid),
    .in_data   (in_item),
    .out_valid (v1),
    .out_data  (d1)
  );

  snc_prefix u_prefix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en2),
    .in_valid  (v1),
    .in_data   (d1),
    .out_valid (v2),
    .out_data  (d2)
  );

  snc_span u_span (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en3),
    .in_valid  (v2),
    .in_data   (d2),
    .out_valid (v3),
    .out_data  (d3)
  );

  // The last stage register doubles as the output register.
  snc_host u_host (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en4),
    .in_valid  (v3),
    .in_data   (d3),
    .out_valid (v4),
    .out_data  (out_item)
  );

  assign out_valid = v4;

endmodule

// File: tb/sv/tb_ipv4_subnet_calculator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_subnet_calculator
// Self-checking bench for the IPv4 subnet calculator: directed corner items,
// then random items under random input gaps and output stalls, each result
// compared field by field with a prediction made when its item went in.
// ----------------------------------------------------------------------------
module tb_ipv4_subnet_calculator;
  import snc_pkg::*;

  // The item selects between a dotted netmask and a prefix length.
  localparam logic MODE_MASK   = 1'b0;
  localparam logic MODE_PREFIX = 1'b1;

  localparam int RANDOM_ITEMS = 2000;
  localparam int CALM_ITEMS   = 200;    // tail of the run with no idling at all
  localparam int BLOCK_ITEMS  = 100;    // idling pressure is redrawn per block
  localparam int DRAIN_CYCLES = 10;     // pipeline is four deep
  localparam int CYCLE_LIMIT  = 200000;

  // First and second octets that sit on class and private-range boundaries.
  localparam logic [7:0] HOT_FIRST [0:13] = '{8'd0, 8'd9, 8'd10, 8'd11, 8'd126, 8'd127,
                                              8'd128, 8'd169, 8'd172, 8'd191, 8'd192,
                                              8'd223, 8'd224, 8'd240};
  localparam logic [7:0] HOT_SECOND [0:8] = '{8'd0, 8'd15, 8'd16, 8'd31, 8'd32, 8'd167,
                                              8'd168, 8'd254, 8'd255};

  // ---------------------------------------------------------------------------
  // Scoreboard: predicts each accepted item and checks results in order.
  // ---------------------------------------------------------------------------
  class subnet_scoreboard;
    out_item_t   expected_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Computes the subnet facts for one item; error items leave every other
    // field at zero.
    function out_item_t predict_subnet(in_item_t it);
      out_item_t   r;
      logic [31:0] inv;
      logic [31:0] mask;
      logic [5:0]  pfx;
      logic [7:0]  oct1;
      logic [32:0] size;
      r = '0;
      if (it.mode == MODE_MASK) begin
        // A contiguous mask inverted is a run of low ones, so adding one
        // clears every bit it had.
        inv = ~it.mask_word;
        if ((inv & (inv + 32'd1)) != 32'd0) begin
          r.status = STAT_NONCONTIG;
          return r;
        end
        pfx = 6'($countones(it.mask_word));
      end else begin
        if (it.prefix_len > PREFIX_MAX) begin
          r.status = STAT_RANGE;
          return r;
        end
        pfx = it.prefix_len;
      end
      mask = 32'hFFFF_FFFF << (32 - pfx);
      size = 33'd1 << (32 - pfx);
      r.status          = STAT_OK;
      r.prefix_out      = pfx;
      r.netmask         = mask;
      r.wildcard_res    = ~mask;
      r.network_addr    = it.ip_addr & mask;
      r.broadcast_addr  = (it.ip_addr & mask) | ~mask;
      r.total_addresses = size;
      if (pfx == PREFIX_MAX) begin
        r.host_count = 32'd1;
      end else if (pfx == PREFIX_P2P) begin
        r.host_count = 32'd2;
      end else begin
        r.first_host = r.network_addr + 32'd1;
        r.last_host  = r.broadcast_addr - 32'd1;
        r.host_count = 32'(size - 33'd2);
      end
      oct1 = it.ip_addr[31:24];
      if (oct1 == OCT_LOOPBACK) r.addr_class = CLS_LOOPBACK;
      else if (oct1 < OCT_B_LO) r.addr_class = CLS_A;
      else if (oct1 < OCT_C_LO) r.addr_class = CLS_B;
      else if (oct1 < OCT_D_LO) r.addr_class = CLS_C;
      else if (oct1 < OCT_E_LO) r.addr_class = CLS_D;
      else r.addr_class = CLS_E;
      r.is_private = (oct1 == OCT_PRIV_A) ||
                     (oct1 == OCT_PRIV_B && it.ip_addr[23:20] == NIB_PRIV_B) ||
                     (it.ip_addr[31:16] == PFX_PRIV_C) ||
                     (it.ip_addr[31:16] == PFX_LINK);
      return r;
    endfunction

    function void note_input(in_item_t it);
      expected_q.push_back(predict_subnet(it));
    endfunction

    function void check_field(string name, logic [32:0] want, logic [32:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("result arrived with no item outstanding");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("status", want.status, got.status);
      check_field("prefix_out", want.prefix_out, got.prefix_out);
      check_field("network_addr", want.network_addr, got.network_addr);
      check_field("broadcast_addr", want.broadcast_addr, got.broadcast_addr);
      check_field("netmask", want.netmask, got.netmask);
      check_field("wildcard_res", want.wildcard_res, got.wildcard_res);
      check_field("first_host", want.first_host, got.first_host);
      check_field("last_host", want.last_host, got.last_host);
      check_field("host_count", want.host_count, got.host_count);
      check_field("total_addresses", want.total_addresses, got.total_addresses);
      check_field("addr_class", want.addr_class, got.addr_class);
      check_field("is_private", want.is_private, got.is_private);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // Idling pressure, in percent, set per block of the random part.
  int unsigned gap_pct;
  int unsigned stall_pct;
  bit          calm;

  subnet_scoreboard sb = new();

  ipv4_subnet_calculator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Both handshakes are sampled at the clock edge, where every signal still
  // holds the value it had during the cycle that just ended.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_item);
      if (out_valid && !out_stall) sb.check_result(out_item);
    end
  end

  // Output back-pressure: random bursts of stalled cycles, none
  // while the run is in its calm tail or the block has pressure switched off.
  initial begin : stall_gen
    int unsigned hold;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
      end else if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        hold = $urandom_range(1, 4);
      end
      out_stall <= (hold != 0);
    end
  end

  // A run that hangs anywhere is cut off here.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Presents one item, sometimes after a short idle burst, and returns once
  // the block has accepted it. The valid stays high into the next item.
  task automatic send_item(input in_item_t it);
    if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_fields(input logic mode, input logic [31:0] ip,
                             input logic [31:0] mask, input logic [5:0] pfx);
    in_item_t it;
    it.mode       = mode;
    it.ip_addr    = ip;
    it.mask_word  = mask;
    it.prefix_len = pfx;
    send_item(it);
  endtask

  // Addresses lean toward octets where the class or the private flag flips.
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    a = $urandom();
    case ($urandom_range(0, 3))
      0: a[31:24] = HOT_FIRST[$urandom_range(0, 13)];
      1: begin
        a[31:24] = HOT_FIRST[$urandom_range(0, 13)];
        a[23:16] = HOT_SECOND[$urandom_range(0, 8)];
      end
      default: ;
    endcase
    return a;
  endfunction

  // Prefix lengths lean toward the ends of the range.
  function automatic logic [5:0] pick_prefix();
    logic [5:0] p;
    case ($urandom_range(0, 9))
      0: p = 6'd0;
      1: p = 6'd1;
      2: p = 6'd30;
      3: p = PREFIX_P2P;
      4: p = PREFIX_MAX;
      default: p = 6'($urandom_range(0, 32));
    endcase
    return p;
  endfunction

  function automatic in_item_t random_item();
    in_item_t   it;
    int unsigned kind;
    it.ip_addr    = pick_addr();
    it.mask_word  = $urandom();
    it.prefix_len = 6'($urandom());
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      it.mode       = MODE_PREFIX;
      it.prefix_len = pick_prefix();
    end else if (kind < 48) begin
      it.mode       = MODE_PREFIX;
      it.prefix_len = 6'($urandom_range(33, 63));
    end else if (kind < 83) begin
      it.mode      = MODE_MASK;
      it.mask_word = 32'hFFFF_FFFF << (32 - pick_prefix());
    end else if (kind < 93) begin
      it.mode = MODE_MASK;
    end else begin
      // A clean mask with one bit flipped; mostly breaks contiguity.
      it.mode      = MODE_MASK;
      it.mask_word = (32'hFFFF_FFFF << (32 - pick_prefix())) ^
                     (32'd1 << $urandom_range(0, 31));
    end
    return it;
  endfunction

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    gap_pct   = 0;
    stall_pct = 0;
    calm      = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Prefix extremes, out-of-range prefixes and the /31 and /32 host rules.
    send_fields(MODE_PREFIX, 32'hC0A8_0A05, 32'h0000_0000, 6'd0);
    send_fields(MODE_PREFIX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd1);
    send_fields(MODE_PREFIX, 32'h0A00_0001, 32'h1234_5678, 6'd30);
    send_fields(MODE_PREFIX, 32'h0A00_0001, 32'h0000_0000, PREFIX_P2P);
    send_fields(MODE_PREFIX, 32'h0000_0000, 32'hFFFF_FFFF, PREFIX_MAX);
    send_fields(MODE_PREFIX, 32'h0102_0304, 32'hFFFF_FF00, 6'd33);
    send_fields(MODE_PREFIX, 32'hFFFF_FFFF, 32'hFFFF_FF00, 6'd63);
    // Masks: all zero, all ones, the ends of contiguity and broken ones.
    send_fields(MODE_MASK, 32'hFFFF_FFFF, 32'h0000_0000, 6'd63);
    send_fields(MODE_MASK, 32'h7F00_0001, 32'hFFFF_FFFF, 6'd0);
    send_fields(MODE_MASK, 32'hAC10_0001, 32'hFFFF_FFFE, 6'd40);
    send_fields(MODE_MASK, 32'hA9FE_0101, 32'h8000_0000, 6'd8);
    send_fields(MODE_MASK, 32'hC0A8_0164, 32'hFFFF_FF00, 6'd24);
    send_fields(MODE_MASK, 32'h0A0A_0A0A, 32'h0000_0001, 6'd24);
    send_fields(MODE_MASK, 32'h0A0A_0A0A, 32'hFF00_FF00, 6'd16);
    send_fields(MODE_MASK, 32'h0A0A_0A0A, 32'h7FFF_FFFF, 6'd16);
    // Classes B to E and the edges of the 172.16/12, 192.168/16 and 169.254/16 ranges.
    send_fields(MODE_PREFIX, 32'hAC1F_FFFF, 32'h0, 6'd12);
    send_fields(MODE_PREFIX, 32'hAC0F_FFFF, 32'h0, 6'd12);
    send_fields(MODE_PREFIX, 32'hAC20_0000, 32'h0, 6'd12);
    send_fields(MODE_PREFIX, 32'hC0A9_0000, 32'h0, 6'd16);
    send_fields(MODE_PREFIX, 32'hA9FD_0000, 32'h0, 6'd16);
    send_fields(MODE_PREFIX, 32'hDFFF_FFFF, 32'h0, 6'd24);
    send_fields(MODE_PREFIX, 32'hE000_0001, 32'h0, 6'd4);
    send_fields(MODE_PREFIX, 32'hEFFF_FFFF, 32'h0, 6'd4);
    send_fields(MODE_PREFIX, 32'hF000_0000, 32'h0, 6'd4);

    // Random part: pressure on each side is redrawn every block so that some
    // blocks run flat out, and the tail runs with no idling at all.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BLOCK_ITEMS == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      send_item(random_item());
    end
    in_valid <= 1'b0;

    // Drain: wait for every outstanding result, then keep watching for DRAIN_CYCLES
    // so a stray extra result would still be caught.
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/snc_pkg.sv
design/snc_check.sv
design/snc_prefix.sv
design/snc_span.sv
design/snc_host.sv
design/ipv4_subnet_calculator.sv
tb/sv/tb_ipv4_subnet_calculator.sv
